### hw/rtl/tpac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller package
// Shared types, constants, the linearization table and the delay scale table.
// ----------------------------------------------------------------------------
package tpac_pkg;

	// Table and timer sizes.
	localparam int TABLE_ENTRIES = 99;
	localparam int TIMER_WIDTH   = 8;
	localparam int LEVEL_W       = 7;
	localparam int REG_W         = 8;
	// Signed width that holds any window, bound or stored delay.
	localparam int WIN_W         = REG_W + 2;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(100);

	// Division by 100 is a multiply by ceil(2^22 / 100) and a shift by 22.
	// The product window * (100 - level) stays below 25600, where this is exact.
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP       = 41944;
	localparam int SCALE_W     = 23;
	localparam int PROD_W      = REG_W + SCALE_W;

	// Event codes.
	localparam logic [1:0] OP_SET_POWER = 2'd0;
	localparam logic [1:0] OP_ZERO_CROSS = 2'd1;
	localparam logic [1:0] OP_TICK      = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_HALF_CYCLE = 2'd0;
	localparam logic [1:0] REG_MARGIN     = 2'd1;
	localparam logic [1:0] REG_PULSE      = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [REG_W-1:0] HALF_CYCLE_RST = REG_W'(78);
	localparam logic [REG_W-1:0] MARGIN_RST     = REG_W'(4);
	localparam logic [REG_W-1:0] PULSE_RST      = REG_W'(2);

	// Percent to level linearization table; entry i serves percent i + 1.
	localparam logic [LEVEL_W-1:0] LIN_ROM [TABLE_ENTRIES] = '{
		7'd6,  7'd9,  7'd11, 7'd13, 7'd14, 7'd16, 7'd17, 7'd18, 7'd19, 7'd21,
		7'd22, 7'd23, 7'd23, 7'd24, 7'd26, 7'd26, 7'd27, 7'd28, 7'd29, 7'd29,
		7'd31, 7'd31, 7'd32, 7'd33, 7'd33, 7'd34, 7'd35, 7'd36, 7'd36, 7'd37,
		7'd38, 7'd38, 7'd39, 7'd39, 7'd41, 7'd41, 7'd42, 7'd42, 7'd43, 7'd43,
		7'd44, 7'd45, 7'd46, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd49, 7'd50,
		7'd51, 7'd51, 7'd52, 7'd53, 7'd53, 7'd54, 7'd54, 7'd55, 7'd56, 7'd57,
		7'd57, 7'd58, 7'd58, 7'd59, 7'd59, 7'd61, 7'd61, 7'd62, 7'd62, 7'd63,
		7'd64, 7'd64, 7'd65, 7'd66, 7'd67, 7'd67, 7'd68, 7'd69, 7'd69, 7'd71,
		7'd71, 7'd72, 7'd73, 7'd74, 7'd74, 7'd76, 7'd77, 7'd77, 7'd78, 7'd79,
		7'd81, 7'd82, 7'd83, 7'd84, 7'd86, 7'd87, 7'd89, 7'd91, 7'd94
	};

	// Input transaction.
	typedef struct packed {
		logic [1:0]       op;
		logic [REG_W-1:0] power_percent;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic               triac_on;
		logic [LEVEL_W-1:0] applied_level;
		logic [REG_W-1:0]   firing_delay;
		logic               timer_running;
	} out_t;

	// Configuration register set.
	typedef struct packed {
		logic [REG_W-1:0] half_cycle_ticks;
		logic [REG_W-1:0] zc_margin;
		logic [REG_W-1:0] pulse_ticks;
	} cfg_t;

	// Controller state. Delay and compare value are signed so that a negative
	// window copied into them keeps its meaning.
	typedef struct packed {
		logic [LEVEL_W-1:0]     level;
		logic signed [WIN_W-1:0] delay_ticks;
		logic signed [WIN_W-1:0] match_at;
		logic [TIMER_WIDTH-1:0] tick_count;
		logic                   running;
		logic                   pulsing;
		logic                   gate;
	} state_t;

	// Linearized level for a requested percent.
	function automatic logic [LEVEL_W-1:0] level_of(input logic [REG_W-1:0] pct);
		logic [LEVEL_W-1:0] idx;
		idx = pct[LEVEL_W-1:0] - LEVEL_W'(1);
		if (pct == '0) begin
			level_of = '0;
		end else if (pct > REG_W'(TABLE_ENTRIES)) begin
			level_of = FULL_LEVEL;
		end else begin
			level_of = LIN_ROM[idx];
		end
	endfunction

	// (100 - level) times the reciprocal of 100, as a constant table.
	function automatic logic [SCALE_W-1:0] scale_of(input logic [LEVEL_W-1:0] lvl);
		logic [SCALE_W-1:0] rest;
		rest = SCALE_W'(FULL_LEVEL - lvl);
		if (lvl > FULL_LEVEL) begin
			scale_of = '0;
		end else begin
			scale_of = SCALE_W'(rest * SCALE_W'(RECIP));
		end
	endfunction

endpackage

### hw/rtl/tpac_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller next-state logic
// Applies one event (set power, zero crossing or tick) to the controller state.
// ----------------------------------------------------------------------------
module tpac_update (
	input  tpac_pkg::cfg_t   cfg,
	input  tpac_pkg::state_t cur,
	input  tpac_pkg::in_t    item,
	output tpac_pkg::state_t nxt
);

	logic signed [tpac_pkg::WIN_W-1:0] window;
	logic signed [tpac_pkg::WIN_W-1:0] bound;
	logic [tpac_pkg::REG_W-1:0]        window_clamped;
	logic [tpac_pkg::LEVEL_W-1:0]      new_level;
	logic [tpac_pkg::PROD_W-1:0]       product;
	logic [tpac_pkg::REG_W-1:0]        new_delay;
	logic [tpac_pkg::TIMER_WIDTH-1:0]  tick_next;

	// Usable window and late-delay bound, both possibly negative.
	always_comb begin
		window = $signed({2'b00, cfg.half_cycle_ticks})
			- $signed({2'b00, cfg.zc_margin})
			- $signed({2'b00, cfg.pulse_ticks});
		bound = $signed({2'b00, cfg.half_cycle_ticks})
			- $signed({2'b00, cfg.pulse_ticks})
			- $signed({3'b000, cfg.zc_margin[tpac_pkg::REG_W-1:1]});
		window_clamped = window[tpac_pkg::WIN_W-1] ? '0 : window[tpac_pkg::REG_W-1:0];
	end

	// Firing delay for a power request: window * (100 - level) / 100.
	always_comb begin
		new_level = tpac_pkg::level_of(item.power_percent);
		product   = tpac_pkg::PROD_W'(window_clamped)
			* tpac_pkg::PROD_W'(tpac_pkg::scale_of(new_level));
		new_delay = product[tpac_pkg::RECIP_SHIFT +: tpac_pkg::REG_W];
	end

	assign tick_next = cur.tick_count + tpac_pkg::TIMER_WIDTH'(1);

	// Event decode.
	always_comb begin
		nxt = cur;
		case (item.op)
			tpac_pkg::OP_SET_POWER: begin
				nxt.level       = new_level;
				nxt.delay_ticks = $signed({2'b00, new_delay});
			end
			tpac_pkg::OP_ZERO_CROSS: begin
				if (cur.level == '0) begin
					nxt.gate = 1'b0;
				end else if (cur.level == tpac_pkg::FULL_LEVEL || cur.delay_ticks == '0) begin
					nxt.gate       = 1'b1;
					nxt.match_at   = cur.delay_ticks;
					nxt.tick_count = '0;
					nxt.running    = 1'b1;
					nxt.pulsing    = 1'b0;
				end else if (cur.delay_ticks > window) begin
					if (cur.delay_ticks > bound) begin
						nxt.gate = 1'b0;
					end else begin
						nxt.delay_ticks = window;
						nxt.match_at    = window;
						nxt.tick_count  = '0;
						nxt.running     = 1'b1;
						nxt.pulsing     = 1'b0;
					end
				end else begin
					nxt.match_at   = cur.delay_ticks;
					nxt.tick_count = '0;
					nxt.running    = 1'b1;
					nxt.pulsing    = 1'b0;
				end
			end
			tpac_pkg::OP_TICK: begin
				if (cur.running) begin
					nxt.tick_count = tick_next;
					if (tick_next == '0) begin
						nxt.gate    = 1'b0;
						nxt.running = 1'b0;
						nxt.pulsing = 1'b0;
					end else if (!cur.pulsing
						&& $signed({2'b00, tick_next}) == cur.match_at) begin
						// Gate pulse: preload the timer so that its wrap ends the pulse.
						nxt.gate       = 1'b1;
						nxt.pulsing    = 1'b1;
						nxt.tick_count = tpac_pkg::TIMER_WIDTH'(0) - cfg.pulse_ticks;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

### hw/rtl/triac_phase_angle_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller
// Linearizes a power request, times the gate pulse from each mains zero
// crossing on a tick timer, and reports the gate level after every event.
// ----------------------------------------------------------------------------
// Every accepted event (set power, zero crossing or timer tick) produces exactly
// one result transaction, in the cycle after it, from a result register. One
// event is accepted per clock cycle unless the input is stalled; the controller
// state is updated in that same cycle by a single pass of next-state logic, so
// the next event sees it at once. The input is stalled only while a result is
// held and the output side stalls. The three 8-bit configuration registers
// (half cycle, margin and pulse ticks) are always ready and should be written
// only while no event is in flight.
module triac_phase_angle_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tpac_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output tpac_pkg::out_t  out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [tpac_pkg::REG_W-1:0] cfg_data
);

	tpac_pkg::cfg_t   cfg_q;
	tpac_pkg::state_t state_q;
	tpac_pkg::state_t state_next;
	tpac_pkg::out_t   out_q;
	logic             out_valid_q;
	logic             in_accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_cycle_ticks <= tpac_pkg::HALF_CYCLE_RST;
			cfg_q.zc_margin        <= tpac_pkg::MARGIN_RST;
			cfg_q.pulse_ticks      <= tpac_pkg::PULSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpac_pkg::REG_HALF_CYCLE: cfg_q.half_cycle_ticks <= cfg_data;
				tpac_pkg::REG_MARGIN:     cfg_q.zc_margin        <= cfg_data;
				tpac_pkg::REG_PULSE:      cfg_q.pulse_ticks      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpac_update u_update (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (in_data),
		.nxt  (state_next)
	);

	// Controller state advances on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_q.triac_on      <= state_next.gate;
			out_q.applied_level <= state_next.level;
			out_q.firing_delay  <= state_next.delay_ticks[tpac_pkg::REG_W-1:0];
			out_q.timer_running <= state_next.running;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The gate is only ever driven while the timer runs.
	a_gate_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.gate |-> state_q.running)
		else $error("gate on with timer stopped");

	// A pulse in progress implies a running timer.
	a_pulse_needs_timer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pulsing |-> state_q.running)
		else $error("pulsing with timer stopped");

	// The applied level never exceeds full power.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.level <= tpac_pkg::FULL_LEVEL)
		else $error("level above full power");

	// Every accepted transaction leaves a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q)
		else $error("accepted transaction lost its result");

endmodule

### tb/triac_phase_angle_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller checker
// Watches the event, result and register channels, predicts the result of
// every accepted event from its own copy of the controller state, and compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module triac_phase_angle_controller_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  tpac_pkg::in_t              in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  tpac_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [tpac_pkg::REG_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         reports_due
);

	// Shadow copy of the configuration registers.
	logic [tpac_pkg::REG_W-1:0] half_cfg;
	logic [tpac_pkg::REG_W-1:0] margin_cfg;
	logic [tpac_pkg::REG_W-1:0] pulse_cfg;

	// Shadow copy of the controller state. Delay and compare value are kept as
	// signed integers, since a negative window can be copied into them.
	logic [tpac_pkg::LEVEL_W-1:0]     lvl;
	int                               delay_cnt;
	int                               match_cnt;
	logic [tpac_pkg::TIMER_WIDTH-1:0] tick_cnt;
	logic                             timer_on;
	logic                             pulse_on;
	logic                             gate_on;

	// Gate reports predicted but not yet seen on the result channel.
	tpac_pkg::out_t expected_reports[$];
	tpac_pkg::out_t predicted;
	int             tally = 0;

	// Applies one event to the shadow state and returns the gate report.
	task automatic advance_controller(input tpac_pkg::in_t ev, output tpac_pkg::out_t rpt);
		int  window;
		int  bound;
		int  pct;
		bit  arm;
		window = int'(half_cfg) - int'(margin_cfg) - int'(pulse_cfg);
		pct = int'(ev.power_percent);
		arm = 1'b0;
		case (ev.op)
			tpac_pkg::OP_SET_POWER: begin
				if (pct == 0)
					lvl = '0;
				else if (pct > tpac_pkg::TABLE_ENTRIES)
					lvl = tpac_pkg::FULL_LEVEL;
				else
					lvl = tpac_pkg::LIN_ROM[pct - 1];
				if (window < 0)
					window = 0;
				delay_cnt = (window * (int'(tpac_pkg::FULL_LEVEL) - int'(lvl)))
					/ int'(tpac_pkg::FULL_LEVEL);
			end
			tpac_pkg::OP_ZERO_CROSS: begin
				if (lvl == '0) begin
					gate_on = 1'b0;
				end else if (lvl == tpac_pkg::FULL_LEVEL || delay_cnt == 0) begin
					// Full conduction: compare value zero is never matched.
					gate_on = 1'b1;
					arm = 1'b1;
				end else if (delay_cnt > window) begin
					// Late firing point: either skip this half cycle or clamp.
					bound = int'(half_cfg) - int'(pulse_cfg) - int'(margin_cfg / 2);
					if (delay_cnt > bound) begin
						gate_on = 1'b0;
					end else begin
						delay_cnt = window;
						arm = 1'b1;
					end
				end else begin
					arm = 1'b1;
				end
				if (arm) begin
					match_cnt = delay_cnt;
					tick_cnt = '0;
					timer_on = 1'b1;
					pulse_on = 1'b0;
				end
			end
			tpac_pkg::OP_TICK: begin
				if (timer_on) begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt == '0) begin
						gate_on = 1'b0;
						timer_on = 1'b0;
						pulse_on = 1'b0;
					end else if (!pulse_on && int'(tick_cnt) == match_cnt) begin
						// Fire and let the wrap end the pulse after pulse_ticks.
						gate_on = 1'b1;
						pulse_on = 1'b1;
						tick_cnt = tpac_pkg::TIMER_WIDTH'((1 << tpac_pkg::TIMER_WIDTH)
							- int'(pulse_cfg));
					end
				end
			end
			default: ;
		endcase
		rpt.triac_on = gate_on;
		rpt.applied_level = lvl;
		rpt.firing_delay = tpac_pkg::REG_W'(delay_cnt);
		rpt.timer_running = timer_on;
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			tally++;
		end
	endtask

	// Track register writes, predict on each event, compare each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cfg = tpac_pkg::HALF_CYCLE_RST;
			margin_cfg = tpac_pkg::MARGIN_RST;
			pulse_cfg = tpac_pkg::PULSE_RST;
			lvl = '0;
			delay_cnt = 0;
			match_cnt = 0;
			tick_cnt = '0;
			timer_on = 1'b0;
			pulse_on = 1'b0;
			gate_on = 1'b0;
			expected_reports.delete();
			reports_due <= 0;
			mismatches <= tally;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tpac_pkg::REG_HALF_CYCLE: half_cfg = cfg_data;
					tpac_pkg::REG_MARGIN:     margin_cfg = cfg_data;
					tpac_pkg::REG_PULSE:      pulse_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_controller(in_data, predicted);
				expected_reports.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction %h arrived with no expected result", out_data);
					tally++;
				end else begin
					predicted = expected_reports.pop_front();
					check_field("triac_on", predicted.triac_on, out_data.triac_on);
					check_field("applied_level", predicted.applied_level,
						out_data.applied_level);
					check_field("firing_delay", predicted.firing_delay, out_data.firing_delay);
					check_field("timer_running", predicted.timer_running,
						out_data.timer_running);
				end
			end
			reports_due <= expected_reports.size();
			mismatches <= tally;
		end
	end

endmodule

### tb/tb_triac_phase_angle_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac phase-angle controller testbench
// Drives directed and random mains half cycles (power requests, zero crossings
// and timer ticks) under several register settings, with random idling on
// both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_triac_phase_angle_controller;

	// Event and register codes that the controller ignores.
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	tpac_pkg::in_t              in_data = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	tpac_pkg::out_t             out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = tpac_pkg::REG_HALF_CYCLE;
	logic [tpac_pkg::REG_W-1:0] cfg_data = '0;
	int                         mismatches;
	int                         reports_due;

	// Traffic shaping shared by the sender and the receiver.
	logic                       calm = 1'b0;
	logic                       hold_phase = 1'b0;
	logic                       hold_done = 1'b0;
	logic [tpac_pkg::REG_W-1:0] cur_half = tpac_pkg::HALF_CYCLE_RST;
	int                         idle_run;

	triac_phase_angle_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	triac_phase_angle_controller_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.reports_due (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls, one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_phase && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 20);
		end
	end

	// End the run when no transaction of any kind moves for too long.
	initial begin
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one event, with random idle cycles first, and waits for acceptance.
	task automatic send_event(input logic [1:0] op, input logic [tpac_pkg::REG_W-1:0] pct);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {op, pct};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stops offering events until every result has been taken.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [tpac_pkg::REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [tpac_pkg::REG_W-1:0] half,
			input logic [tpac_pkg::REG_W-1:0] margin,
			input logic [tpac_pkg::REG_W-1:0] pulse);
		quiesce();
		write_reg(tpac_pkg::REG_HALF_CYCLE, half);
		write_reg(tpac_pkg::REG_MARGIN, margin);
		write_reg(tpac_pkg::REG_PULSE, pulse);
		cur_half = half;
	endtask

	// Power request mix: off, clamped full power and the table range.
	function automatic logic [tpac_pkg::REG_W-1:0] pick_percent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 25)
			return tpac_pkg::REG_W'($urandom_range(100, 255));
		else
			return tpac_pkg::REG_W'($urandom_range(1, 99));
	endfunction

	// Mostly well-formed half cycles (optional request, zero crossing, a run of
	// ticks, sometimes through the wrap), with some random events mixed in.
	task automatic run_mains(input int budget);
		int         sent;
		int         n;
		int         k;
		logic [1:0] op;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 99) < 10) begin
				op = 2'($urandom_range(0, 3));
				send_event(op, tpac_pkg::REG_W'($urandom_range(0, 255)));
				if (op != OP_UNUSED)
					sent++;
			end else begin
				if ($urandom_range(0, 1) == 1) begin
					send_event(tpac_pkg::OP_SET_POWER, pick_percent());
					sent++;
				end
				send_event(tpac_pkg::OP_ZERO_CROSS, tpac_pkg::REG_W'($urandom_range(0, 255)));
				sent++;
				if ($urandom_range(0, 99) < 20)
					n = $urandom_range(256, 262);
				else
					n = $urandom_range(1, int'(cur_half) + 6);
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 99) < 3) begin
						send_event(tpac_pkg::OP_SET_POWER, pick_percent());
					end else if ($urandom_range(0, 99) < 2) begin
						send_event(OP_UNUSED, tpac_pkg::REG_W'($urandom_range(0, 255)));
						sent--;
					end else begin
						send_event(tpac_pkg::OP_TICK, tpac_pkg::REG_W'($urandom_range(0, 255)));
					end
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events at the reset register values.
		send_event(tpac_pkg::OP_TICK, 8'h00);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'hFF);
		send_event(tpac_pkg::OP_SET_POWER, 8'd255);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		send_event(tpac_pkg::OP_TICK, 8'h00);
		send_event(tpac_pkg::OP_TICK, 8'h00);
		send_event(tpac_pkg::OP_SET_POWER, 8'd0);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		send_event(OP_UNUSED, 8'hAA);
		send_event(tpac_pkg::OP_SET_POWER, 8'd1);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		// A request while the timer runs leaves the timer alone.
		send_event(tpac_pkg::OP_SET_POWER, 8'd99);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		// Match on the fourth tick, then the pulse ends at the wrap.
		repeat (6) send_event(tpac_pkg::OP_TICK, 8'h00);
		send_event(tpac_pkg::OP_SET_POWER, 8'd100);
		send_event(tpac_pkg::OP_SET_POWER, 8'd101);
		send_event(tpac_pkg::OP_SET_POWER, 8'd50);
		send_event(OP_UNUSED, 8'h55);

		// Late firing point that skips the half cycle.
		send_event(tpac_pkg::OP_SET_POWER, 8'd1);
		set_config(8'd60, 8'd4, 8'd2);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		// Late firing point that is clamped to the window.
		set_config(8'd71, 8'd4, 8'd2);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		send_event(tpac_pkg::OP_SET_POWER, 8'd99);
		// Negative window copied into the delay.
		set_config(8'd30, 8'd30, 8'd1);
		send_event(tpac_pkg::OP_ZERO_CROSS, 8'h00);
		repeat (3) send_event(tpac_pkg::OP_TICK, 8'h00);
		quiesce();
		write_reg(REG_UNUSED, tpac_pkg::REG_W'($urandom_range(0, 255)));

		// Random half cycles at the reset values, part of it with no idling.
		set_config(tpac_pkg::HALF_CYCLE_RST, tpac_pkg::MARGIN_RST, tpac_pkg::PULSE_RST);
		run_mains(230);
		calm <= 1'b1;
		run_mains(120);
		calm <= 1'b0;

		// Short half cycle; the receiver holds off long enough to stall events.
		set_config(8'd20, 8'd0, 8'd1);
		hold_phase <= 1'b1;
		run_mains(300);

		// Longest half cycle, with one pause until all results are in.
		set_config(8'd255, 8'd0, 8'd1);
		run_mains(150);
		quiesce();
		run_mains(150);

		// Window below zero: after a new request, any nonzero level fires at once.
		set_config(8'd255, 8'd255, 8'd255);
		run_mains(120);

		// Smallest half cycle: window zero.
		set_config(8'd1, 8'd0, 8'd1);
		run_mains(120);

		set_config(8'd100, 8'd30, 8'd50);
		write_reg(REG_UNUSED, tpac_pkg::REG_W'($urandom_range(0, 255)));
		run_mains(250);

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
